// ----- rtl/rlc_pkg.sv -----
// ============================================================================
// rlc_pkg
// Shared codes, character constants, microcode word layout and the control
// program of the radix line converter.
// ============================================================================
package rlc_pkg;

	// ASCII characters the parser looks for
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_I  = 8'h69;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_H  = 8'h68;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	// 'a' minus ten: maps 'a'..'f' onto 10..15
	localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;

	// radix codes, also used as source selector of the load step
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_HEX = 2'd1;
	localparam logic [1:0] RADIX_BIN = 2'd2;

	// micro operations
	localparam logic [2:0] OP_SELECT = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1;
	localparam logic [2:0] OP_DABBLE = 3'd2;
	localparam logic [2:0] OP_PREP   = 3'd3;
	localparam logic [2:0] OP_EMIT   = 3'd4;
	localparam logic [2:0] OP_DONE   = 3'd5;

	// program addresses
	localparam int         STEP_W      = 5;
	localparam logic [4:0] STEP_SELECT = 5'd0;
	localparam logic [4:0] ENTRY_BIN   = 5'd1;
	localparam logic [4:0] ENTRY_HEX   = 5'd8;
	localparam logic [4:0] ENTRY_DEC   = 5'd15;
	localparam logic [4:0] STEP_LAST   = 5'd20;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] sel;   // radix of a prep/emit step, source of a load step
		logic       last;  // emission closes the line
	} uword_t;

	// line status handed from the character parser to the sequencer
	typedef struct packed {
		logic       is_bin;
		logic       is_hex;
		logic [2:0] ovf;   // bit 0 binary, bit 1 hex, bit 2 decimal wrapped
	} line_stat_t;

	// control program: one word per step
	function automatic uword_t rom_word(input logic [STEP_W-1:0] step);
		uword_t w;
		unique case (step)
			5'd0:    w = '{OP_SELECT, RADIX_DEC, 1'b0};
			// base word "bin": binary reading as decimal then hex
			5'd1:    w = '{OP_LOAD,   RADIX_BIN, 1'b0};
			5'd2:    w = '{OP_DABBLE, RADIX_DEC, 1'b0};
			5'd3:    w = '{OP_PREP,   RADIX_DEC, 1'b0};
			5'd4:    w = '{OP_EMIT,   RADIX_DEC, 1'b0};
			5'd5:    w = '{OP_PREP,   RADIX_HEX, 1'b0};
			5'd6:    w = '{OP_EMIT,   RADIX_HEX, 1'b1};
			5'd7:    w = '{OP_DONE,   RADIX_DEC, 1'b0};
			// base word "hex": hex reading as decimal then binary
			5'd8:    w = '{OP_LOAD,   RADIX_HEX, 1'b0};
			5'd9:    w = '{OP_DABBLE, RADIX_DEC, 1'b0};
			5'd10:   w = '{OP_PREP,   RADIX_DEC, 1'b0};
			5'd11:   w = '{OP_EMIT,   RADIX_DEC, 1'b0};
			5'd12:   w = '{OP_PREP,   RADIX_BIN, 1'b0};
			5'd13:   w = '{OP_EMIT,   RADIX_BIN, 1'b1};
			5'd14:   w = '{OP_DONE,   RADIX_DEC, 1'b0};
			// any other base word: decimal reading as hex then binary
			5'd15:   w = '{OP_LOAD,   RADIX_DEC, 1'b0};
			5'd16:   w = '{OP_PREP,   RADIX_HEX, 1'b0};
			5'd17:   w = '{OP_EMIT,   RADIX_HEX, 1'b0};
			5'd18:   w = '{OP_PREP,   RADIX_BIN, 1'b0};
			5'd19:   w = '{OP_EMIT,   RADIX_BIN, 1'b1};
			5'd20:   w = '{OP_DONE,   RADIX_DEC, 1'b0};
			default: w = '{OP_DONE,   RADIX_DEC, 1'b0};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/rlc_line_acc.sv -----
// ============================================================================
// rlc_line_acc
// Character parser: keeps the binary, hex and decimal readings of the number
// and the first three characters of the base word for the current line.
// ============================================================================
module rlc_line_acc #(
	parameter int VALUE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,       // character request accepted
	input  logic [7:0]             char_code,
	input  logic                   clear,      // line finished
	output logic [VALUE_BITS-1:0]  bin_acc,
	output logic [VALUE_BITS-1:0]  hex_acc,
	output logic [VALUE_BITS-1:0]  dec_acc,
	output rlc_pkg::line_stat_t    stat
);
	import rlc_pkg::*;

	logic [VALUE_BITS-1:0] bin_q;
	logic [VALUE_BITS-1:0] hex_q;
	logic [VALUE_BITS-1:0] dec_q;
	logic [2:0]            ovf_q;
	logic                  in_suffix_q;
	logic                  dec_stop_q;
	logic [7:0]            sfx_q [3];
	logic [2:0]            sfx_len_q;

	logic                  is_char;
	logic                  is_space;
	logic                  is_alpha;
	logic                  is_digit;
	logic [7:0]            hex_diff;
	logic [7:0]            dec_diff;
	logic [3:0]            hex_dig;
	logic [VALUE_BITS+3:0] dec_next;

	// classify the character
	assign is_char  = take && (char_code != CH_NUL);
	assign is_space = (char_code == CH_SPACE);
	assign is_alpha = (char_code >= CH_LC_A) && (char_code <= CH_LC_F);
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign hex_diff = is_alpha ? (char_code - HEX_ALPHA_OFS) : (char_code - CH_ZERO);
	assign dec_diff = char_code - CH_ZERO;
	assign hex_dig  = hex_diff[3:0];

	// decimal step: times eight plus times two plus the digit
	assign dec_next = {1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0}
		+ {{VALUE_BITS{1'b0}}, dec_diff[3:0]};

	// update the readings and the base word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q       <= '0;
			hex_q       <= '0;
			dec_q       <= '0;
			ovf_q       <= '0;
			in_suffix_q <= 1'b0;
			dec_stop_q  <= 1'b0;
			sfx_q       <= '{default: '0};
			sfx_len_q   <= '0;
		end else if (clear) begin
			bin_q       <= '0;
			hex_q       <= '0;
			dec_q       <= '0;
			ovf_q       <= '0;
			in_suffix_q <= 1'b0;
			dec_stop_q  <= 1'b0;
			sfx_q       <= '{default: '0};
			sfx_len_q   <= '0;
		end else if (is_char) begin
			priority if (is_space) begin
				in_suffix_q <= 1'b1;
			end else if (in_suffix_q) begin
				if (sfx_len_q < 3'd3) begin
					sfx_q[sfx_len_q[1:0]] <= char_code;
				end
				if (sfx_len_q < 3'd4) begin
					sfx_len_q <= sfx_len_q + 3'd1;
				end
			end else begin
				// binary: anything but '0' counts as one
				if (bin_q[VALUE_BITS-1]) begin
					ovf_q[0] <= 1'b1;
				end
				bin_q <= {bin_q[VALUE_BITS-2:0], char_code != CH_ZERO};
				// hex
				if (hex_q[VALUE_BITS-1 -: 4] != 4'd0) begin
					ovf_q[1] <= 1'b1;
				end
				hex_q <= {hex_q[VALUE_BITS-5:0], hex_dig};
				// decimal stops at the first non-digit
				if (!dec_stop_q) begin
					if (is_digit) begin
						if (dec_next[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
							ovf_q[2] <= 1'b1;
						end
						dec_q <= dec_next[VALUE_BITS-1:0];
					end else begin
						dec_stop_q <= 1'b1;
					end
				end
			end
		end
	end

	assign bin_acc = bin_q;
	assign hex_acc = hex_q;
	assign dec_acc = dec_q;

	// match the base word
	assign stat.is_bin = (sfx_len_q == 3'd3) && (sfx_q[0] == CH_LC_B)
		&& (sfx_q[1] == CH_LC_I) && (sfx_q[2] == CH_LC_N);
	assign stat.is_hex = (sfx_len_q == 3'd3) && (sfx_q[0] == CH_LC_H)
		&& (sfx_q[1] == CH_LC_E) && (sfx_q[2] == CH_LC_X);
	assign stat.ovf    = ovf_q;

endmodule

// ----- rtl/radix_line_converter.sv -----
// ============================================================================
// radix_line_converter
// Reads a text line "number base-word" one character at a time and emits the
// number in two other radixes, one digit per result.
// ============================================================================
// Usage:
//   Slave channel: one ASCII character per request, tlast on the last
//   character of the line. Characters are taken one per cycle while the sequencer is idle.
//   Master channel: one digit per request, most significant first, leading
//   zeros dropped (zero gives the single digit 0). tuser carries the radix,
//   the end of one representation and the overflow flag; tlast marks the
//   last digit of the line.
//   After the line's last character a microcoded sequencer runs from a
//   21-step control table. A "bin" or "hex" line runs a select step, a
//   load step, a double-dabble step looped over VALUE_BITS, a prep step and
//   an emit step per radix, and a done step; any other line skips the
//   double-dabble. The emit step visits every digit position, shown or
//   dropped, so the digit scan sets the line-end time.
//   s_tready is low from the accepted line end through the done step.
//   Reset clears the parser, the sequencer and m_tvalid, not the data registers.
//   A stalled receiver holds the current digit; the sequencer waits on an emit
//   step with a digit to show until the output register frees up.
// ============================================================================
module radix_line_converter #(
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // end_of_line
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] digit_value, [7:4] zero
	output logic [3:0] m_tuser,   // [1:0] radix_code, [2] number_done, [3] overflow
	output logic       m_tlast    // line_done
);
	import rlc_pkg::*;

	localparam int NDEC  = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int NHEX  = (VALUE_BITS + 3) / 4;
	localparam int EMW   = 4 * NDEC;
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic [STEP_W-1:0]     pc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  started_q;
	logic                  ovf_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [EMW-1:0]        bcd_q;
	logic [EMW-1:0]        em_q;

	logic                  m_tvalid_q;
	logic [3:0]            digit_q;
	logic [1:0]            radix_q;
	logic                  num_done_q;
	logic                  line_done_q;
	logic                  out_ovf_q;

	uword_t                uw;
	line_stat_t            stat;
	logic [VALUE_BITS-1:0] bin_acc;
	logic [VALUE_BITS-1:0] hex_acc;
	logic [VALUE_BITS-1:0] dec_acc;
	logic                  take;
	logic                  line_clear;
	logic                  slot_free;
	logic                  last_pos;
	logic [3:0]            cur_digit;
	logic                  skip;
	logic                  emit_fire;
	logic                  em_adv;
	logic [VALUE_BITS-1:0] load_val;
	logic                  load_ovf;
	logic [4*NHEX-1:0]     hex_pad;
	logic [EMW-1:0]        em_hex;
	logic [EMW-1:0]        em_bin;
	logic [EMW-1:0]        bcd_adj;
	logic [EMW-1:0]        em_shift;

	// current control word
	assign uw         = rom_word(pc_q);
	assign s_tready   = !busy_q;
	assign take       = s_tvalid && s_tready;
	assign line_clear = busy_q && (uw.op == OP_DONE);

	rlc_line_acc #(
		.VALUE_BITS(VALUE_BITS)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.char_code(s_tdata),
		.clear    (line_clear),
		.bin_acc  (bin_acc),
		.hex_acc  (hex_acc),
		.dec_acc  (dec_acc),
		.stat     (stat)
	);

	// pick the reading named by the load step
	always_comb begin
		unique case (uw.sel)
			RADIX_BIN: begin
				load_val = bin_acc;
				load_ovf = stat.ovf[0];
			end
			RADIX_HEX: begin
				load_val = hex_acc;
				load_ovf = stat.ovf[1];
			end
			default: begin
				load_val = dec_acc;
				load_ovf = stat.ovf[2];
			end
		endcase
	end

	// left-align the value for digit scanning
	assign hex_pad = (4 * NHEX)'(val_q);
	assign em_hex  = EMW'(hex_pad) << (EMW - 4 * NHEX);
	assign em_bin  = EMW'(val_q) << (EMW - VALUE_BITS);

	// double-dabble correction: add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < NDEC; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				(bcd_q[4*i +: 4] + 4'd3) : bcd_q[4*i +: 4];
		end
	end

	// top digit and scan control of the emit step
	assign cur_digit = (uw.sel == RADIX_BIN) ? {3'b000, em_q[EMW-1]} : em_q[EMW-1 -: 4];
	assign em_shift  = (uw.sel == RADIX_BIN) ? (em_q << 1) : (em_q << 4);
	assign last_pos  = (cnt_q == CNT_W'(1));
	assign slot_free = !m_tvalid_q || m_tready;
	assign skip      = (cur_digit == 4'd0) && !started_q && !last_pos;
	assign em_adv    = busy_q && (uw.op == OP_EMIT) && (skip || slot_free);
	assign emit_fire = busy_q && (uw.op == OP_EMIT) && !skip && slot_free;

	// sequencer: step counter, loop counter and jumps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pc_q      <= STEP_SELECT;
			cnt_q     <= '0;
			started_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (!busy_q) begin
			if (take && s_tlast) begin
				busy_q <= 1'b1;
				pc_q   <= STEP_SELECT;
			end
		end else begin
			unique case (uw.op)
				OP_SELECT: begin
					priority if (stat.is_bin) begin
						pc_q <= ENTRY_BIN;
					end else if (stat.is_hex) begin
						pc_q <= ENTRY_HEX;
					end else begin
						pc_q <= ENTRY_DEC;
					end
				end
				OP_LOAD: begin
					ovf_q <= load_ovf;
					cnt_q <= CNT_W'(VALUE_BITS);
					pc_q  <= pc_q + 5'd1;
				end
				OP_DABBLE: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (last_pos) begin
						pc_q <= pc_q + 5'd1;
					end
				end
				OP_PREP: begin
					started_q <= 1'b0;
					unique case (uw.sel)
						RADIX_BIN: cnt_q <= CNT_W'(VALUE_BITS);
						RADIX_HEX: cnt_q <= CNT_W'(NHEX);
						default:   cnt_q <= CNT_W'(NDEC);
					endcase
					pc_q <= pc_q + 5'd1;
				end
				OP_EMIT: begin
					if (em_adv) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (!skip) begin
							started_q <= 1'b1;
						end
						if (last_pos) begin
							pc_q <= pc_q + 5'd1;
						end
					end
				end
				OP_DONE: begin
					busy_q <= 1'b0;
					pc_q   <= STEP_SELECT;
				end
				default: begin
					busy_q <= 1'b0;
					pc_q   <= STEP_SELECT;
				end
			endcase
		end
	end

	// datapath registers driven by the control word
	always_ff @(posedge clk) begin
		if (busy_q) begin
			unique case (uw.op)
				OP_LOAD: begin
					val_q <= load_val;
					em_q  <= EMW'(load_val) << (EMW - VALUE_BITS);
					bcd_q <= '0;
				end
				OP_DABBLE: begin
					bcd_q <= {bcd_adj[EMW-2:0], em_q[EMW-1]};
					em_q  <= em_q << 1;
				end
				OP_PREP: begin
					unique case (uw.sel)
						RADIX_BIN: em_q <= em_bin;
						RADIX_HEX: em_q <= em_hex;
						default:   em_q <= bcd_q;
					endcase
				end
				OP_EMIT: begin
					if (em_adv) begin
						em_q <= em_shift;
					end
				end
				default: begin
					em_q <= em_q;
				end
			endcase
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			digit_q     <= cur_digit;
			radix_q     <= uw.sel;
			num_done_q  <= last_pos;
			line_done_q <= last_pos && uw.last;
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, digit_q};
	assign m_tuser  = {out_ovf_q, num_done_q, radix_q};
	assign m_tlast  = line_done_q;

	// the line end stops further characters until the sequencer is done
	a_line_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("character taken right after a line end");

	// the line's last digit also closes its representation
	a_line_done_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[2])
		else $error("line end without number end");

	// digits stay within their radix
	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == RADIX_DEC) |-> (m_tdata[3:0] <= 4'd9))
		else $error("decimal digit out of range");

	a_bin_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == RADIX_BIN) |-> (m_tdata[3:1] == 3'd0))
		else $error("binary digit out of range");

	// the step counter stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= STEP_LAST)
		else $error("step counter left the program");

	// a new digit is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> (!m_tvalid || m_tready))
		else $error("digit overwritten before delivery");

endmodule
